// ===== hdl/bilinear_table_interpolator_assert.svh =====
// ----------------------------------------------------------------------------
// Bilinear table interpolator assertion macros
// Clocked assertion forms shared by the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define BTI_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BTI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear table interpolator package
// Shared codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package bti_pkg;

    localparam int MAX_X_POINTS_DEF = 64;
    localparam int MAX_Y_POINTS_DEF = 64;

    localparam logic [1:0] CMD_LOAD_X = 2'd0;
    localparam logic [1:0] CMD_LOAD_Y = 2'd1;
    localparam logic [1:0] CMD_LOAD_G = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] ST_INTERP = 2'd0;
    localparam logic [1:0] ST_EXTRAP = 2'd1;
    localparam logic [1:0] ST_OOR    = 2'd2;

    localparam logic REG_X_COUNT = 1'b0;
    localparam logic REG_Y_COUNT = 1'b1;

    // Fraction quotient is |num| * 2^16 / den with |num| below 2^33.
    localparam int QUO_W = 49;
    localparam int VAL_W = 42;
    localparam int DIF_W = 43;
    localparam int ACC_W = 57;
    localparam int CHK_W = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RX0,
        S_RXL,
        S_RY0,
        S_RYL,
        S_DEC,
        S_SRD,
        S_SCMP,
        S_FRD0,
        S_FRD1,
        S_FDEN,
        S_DIV,
        S_GRD,
        S_MI,
        S_MACC,
        S_MFIN
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/bilinear_table_interpolator.sv =====
// Loads are taken one item per cycle while no query is in work. A query's run time is
// set mostly by two fraction divisions in the shared restoring divider, plus up to two
// binary searches on the breakpoint memory and three blends.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears the sequencer and output valid and sets both point counts to 2;
// the breakpoint and grid memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_table_interpolator_assert.svh"
// ----------------------------------------------------------------------------
// Bilinear table interpolator
// Breakpoint tables and value grid in synchronous memories, searched and
// blended by a sequencer with a shared divider and multiplier.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator #(
    parameter int MAX_X_POINTS = bti_pkg::MAX_X_POINTS_DEF,
    parameter int MAX_Y_POINTS = bti_pkg::MAX_Y_POINTS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [1:0]         i_command,
    input  wire  [5:0]         i_x_slot,
    input  wire  [5:0]         i_y_slot,
    input  wire  signed [31:0] i_load_word,
    input  wire  signed [31:0] i_query_x,
    input  wire  signed [31:0] i_query_y,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [31:0] o_interp_value,
    output logic [1:0]         o_status,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire                i_cfg_index,
    input  wire  [6:0]         i_cfg_data
);
    import bti_pkg::*;

    localparam int MX   = MAX_X_POINTS;
    localparam int MY   = MAX_Y_POINTS;
    localparam int XCW  = $clog2(MX + 1);
    localparam int YCW  = $clog2(MY + 1);
    localparam int MAXP = (MX > MY) ? MX : MY;
    localparam int IW   = $clog2(MAXP);
    localparam int BD   = MX + MY;
    localparam int BAW  = $clog2(BD);
    localparam int GD   = MX * MY;
    localparam int GAW  = $clog2(GD);

    localparam logic signed [DIF_W-1:0] LIM_P = 43'sh100_0000_0000;
    localparam logic signed [DIF_W-1:0] LIM_N = -43'sh100_0000_0000;
    localparam logic [40:0]             LIM_M = 41'h100_0000_0000;
    localparam logic signed [VAL_W-1:0] MAX32 = 42'sh0_7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] MIN32 = -42'sh0_8000_0000;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [XCW-1:0] r_x_cnt, n_x_cnt;
    logic [YCW-1:0] r_y_cnt, n_y_cnt;

    logic signed [31:0] r_bp_mem [BD];
    logic signed [31:0] r_g_mem  [GD];
    logic signed [31:0] r_bp_q, r_g_q;
    logic               bp_we, g_we;
    logic [BAW-1:0]     bp_waddr, bp_raddr;
    logic [GAW-1:0]     g_waddr, g_raddr;

    logic signed [31:0] r_qx, n_qx, r_qy, n_qy;
    logic signed [31:0] r_x0, n_x0, r_xl, n_xl, r_y0, n_y0;
    logic               r_outer_x, n_outer_x, r_srch_y, n_srch_y;
    logic [1:0]         r_status, n_status;
    logic               r_sel, n_sel;
    logic [IW-1:0]      r_lo, n_lo, r_hi, n_hi, r_mid, n_mid, r_ix, n_ix, r_iy, n_iy;
    logic signed [31:0] r_base, n_base;
    logic [QUO_W-1:0]   r_div_q, n_div_q;
    logic [31:0]        r_rem, n_rem, r_den, n_den;
    logic [5:0]         r_dcnt, n_dcnt;
    logic               r_dneg, n_dneg;
    logic [QUO_W-1:0]   r_fx_mag, n_fx_mag, r_fy_mag, n_fy_mag;
    logic               r_fx_neg, n_fx_neg, r_fy_neg, n_fy_neg;
    logic [2:0]         r_gk, n_gk;
    logic signed [31:0] r_corner [4];
    logic               corner_we;
    logic [1:0]         corner_wi;
    logic [1:0]         r_step, n_step;
    logic [DIF_W-1:0]   r_ua, n_ua;
    logic               r_mneg, n_mneg;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic               r_sat, n_sat;
    logic [1:0]         r_mk, n_mk;
    logic signed [VAL_W-1:0] r_l0, n_l0, r_l1, n_l1;
    logic signed [31:0] r_res, n_res;
    logic signed [31:0] r_out_value, n_out_value;
    logic [1:0]         r_out_status, n_out_status;

    logic               in_acc;
    logic [31:0]        cfg_w;
    logic signed [31:0] q_sel;
    logic [IW-1:0]      idx_sel;
    logic signed [32:0] fr_den, fr_num;
    logic [32:0]        num_mag;
    logic [32:0]        div_t;
    logic               div_ge;
    logic [31:0]        div_r;
    logic [IW:0]        s_span;
    logic [IW-1:0]      s_mid;
    logic               x_in, y_in;
    logic signed [VAL_W-1:0] lp_a, lp_b;
    logic [QUO_W-1:0]   lp_fmag;
    logic               lp_fneg;
    logic signed [DIF_W-1:0] lp_diff;
    logic [DIF_W-1:0]   lp_ua;
    logic [63:0]        fpad;
    logic [CHK_W-1:0]   chunk;
    logic [58:0]        mprod;
    logic [73:0]        macc;
    logic [40:0]        acc_hi, mag;
    logic signed [DIF_W-1:0] smag, lsum;
    logic signed [VAL_W-1:0] lres;
    logic signed [31:0] res32;
    logic               gdx, gdy;
    logic [IW-1:0]      gcol, grow;

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_status       = r_out_status;
    assign in_acc         = i_in_valid && !o_in_stall;
    assign cfg_w          = {25'd0, i_cfg_data};

    always_comb begin
        n_x_cnt = r_x_cnt;
        n_y_cnt = r_y_cnt;
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_X_COUNT) begin
                n_x_cnt = (cfg_w < 32'd2) ? XCW'(2) :
                          (cfg_w > 32'(MX)) ? XCW'(MX) : XCW'(cfg_w);
            end
            if (i_cfg_index == REG_Y_COUNT) begin
                n_y_cnt = (cfg_w < 32'd2) ? YCW'(2) :
                          (cfg_w > 32'(MY)) ? YCW'(MY) : YCW'(cfg_w);
            end
        end
    end

    assign bp_we = in_acc &&
        ((i_command == CMD_LOAD_X && 32'(i_x_slot) < 32'(MX)) ||
         (i_command == CMD_LOAD_Y && 32'(i_y_slot) < 32'(MY)));
    assign bp_waddr = (i_command == CMD_LOAD_X) ? BAW'(32'(i_x_slot)) :
                                                  BAW'(32'(MX) + 32'(i_y_slot));
    assign g_we = in_acc && i_command == CMD_LOAD_G &&
                  32'(i_x_slot) < 32'(MX) && 32'(i_y_slot) < 32'(MY);
    assign g_waddr = GAW'(32'(i_x_slot) * 32'(MY) + 32'(i_y_slot));

    always_ff @(posedge i_clk) begin
        if (bp_we) begin
            r_bp_mem[bp_waddr] <= i_load_word;
        end
        r_bp_q <= r_bp_mem[bp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_g_mem[g_waddr] <= i_load_word;
        end
        r_g_q <= r_g_mem[g_raddr];
    end

    assign q_sel   = r_sel ? r_qy : r_qx;
    assign idx_sel = r_sel ? r_iy : r_ix;
    assign fr_den  = $signed({r_bp_q[31], r_bp_q}) - $signed({r_base[31], r_base});
    assign fr_num  = $signed({q_sel[31], q_sel}) - $signed({r_base[31], r_base});
    assign num_mag = fr_num[32] ? 33'(-fr_num) : 33'(fr_num);
    assign div_t   = {r_rem, r_div_q[QUO_W-1]};
    assign div_ge  = div_t >= {1'b0, r_den};
    assign div_r   = div_ge ? 32'(div_t - {1'b0, r_den}) : div_t[31:0];
    assign s_span  = (IW+1)'(r_hi) - (IW+1)'(r_lo);
    assign s_mid   = IW'(((IW+1)'(r_lo) + (IW+1)'(r_hi)) >> 1);
    assign x_in    = (r_qx > r_x0) && (r_qx < r_xl);
    assign y_in    = (r_qy > r_y0) && (r_qy < r_bp_q);

    assign gdx  = r_outer_x ? r_gk[1] : r_gk[0];
    assign gdy  = r_outer_x ? r_gk[0] : r_gk[1];
    assign gcol = r_ix + IW'(gdx);
    assign grow = r_iy + IW'(gdy);
    assign g_raddr = GAW'(32'(gcol) * 32'(MY) + 32'(grow));

    always_comb begin
        case (r_step)
            2'd0: begin
                lp_a = VAL_W'(r_corner[0]);
                lp_b = VAL_W'(r_corner[1]);
            end
            2'd1: begin
                lp_a = VAL_W'(r_corner[2]);
                lp_b = VAL_W'(r_corner[3]);
            end
            default: begin
                lp_a = r_l0;
                lp_b = r_l1;
            end
        endcase
        if ((r_step == 2'd2) == r_outer_x) begin
            lp_fmag = r_fx_mag;
            lp_fneg = r_fx_neg;
        end else begin
            lp_fmag = r_fy_mag;
            lp_fneg = r_fy_neg;
        end
    end

    assign lp_diff = $signed({lp_b[VAL_W-1], lp_b}) - $signed({lp_a[VAL_W-1], lp_a});
    assign lp_ua   = lp_diff[DIF_W-1] ? DIF_W'(-lp_diff) : DIF_W'(lp_diff);
    assign fpad    = {15'd0, lp_fmag};
    assign chunk   = fpad[{r_mk, 4'd0} +: CHK_W];
    assign mprod   = 59'(r_ua) * 59'(chunk);
    assign macc    = 74'({r_acc, 16'd0}) + 74'(mprod);
    assign acc_hi  = r_acc[ACC_W-1:16];
    assign mag     = (r_sat || acc_hi > LIM_M) ? LIM_M : acc_hi;
    assign smag    = r_mneg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    assign lsum    = $signed({lp_a[VAL_W-1], lp_a}) + smag;
    assign lres    = (lsum > LIM_P) ? VAL_W'(LIM_P) :
                     (lsum < LIM_N) ? VAL_W'(LIM_N) : lsum[VAL_W-1:0];
    assign res32   = (lres > MAX32) ? 32'sh7FFF_FFFF :
                     (lres < MIN32) ? 32'sh8000_0000 : lres[31:0];

    assign corner_we = (r_state == S_GRD) && (r_gk != 3'd0);
    assign corner_wi = 2'(r_gk - 3'd1);

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_qx = r_qx;  n_qy = r_qy;
        n_x0 = r_x0;  n_xl = r_xl;  n_y0 = r_y0;
        n_outer_x = r_outer_x;  n_srch_y = r_srch_y;  n_status = r_status;
        n_sel = r_sel;  n_lo = r_lo;  n_hi = r_hi;  n_mid = r_mid;
        n_ix = r_ix;  n_iy = r_iy;  n_base = r_base;
        n_div_q = r_div_q;  n_rem = r_rem;  n_den = r_den;
        n_dcnt = r_dcnt;  n_dneg = r_dneg;
        n_fx_mag = r_fx_mag;  n_fx_neg = r_fx_neg;
        n_fy_mag = r_fy_mag;  n_fy_neg = r_fy_neg;
        n_gk = r_gk;  n_step = r_step;
        n_ua = r_ua;  n_mneg = r_mneg;  n_acc = r_acc;  n_sat = r_sat;  n_mk = r_mk;
        n_l0 = r_l0;  n_l1 = r_l1;  n_res = r_res;
        bp_raddr = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_command == CMD_QUERY) begin
                    n_qx    = i_query_x;
                    n_qy    = i_query_y;
                    n_state = S_RX0;
                end
            end
            S_RX0: begin
                bp_raddr = '0;
                n_state  = S_RXL;
            end
            S_RXL: begin
                bp_raddr = BAW'(32'(r_x_cnt) - 32'd1);
                n_x0     = r_bp_q;
                n_state  = S_RY0;
            end
            S_RY0: begin
                bp_raddr = BAW'(MX);
                n_xl     = r_bp_q;
                n_state  = S_RYL;
            end
            S_RYL: begin
                bp_raddr = BAW'(32'(MX) + 32'(r_y_cnt) - 32'd1);
                n_y0     = r_bp_q;
                n_state  = S_DEC;
            end
            S_DEC: begin
                n_lo    = '0;
                n_state = S_SRD;
                n_sel   = 1'b0;
                n_hi    = IW'(r_x_cnt - XCW'(1));
                n_status = ST_INTERP;
                if (r_qx <= r_x0 && y_in) begin
                    n_outer_x = 1'b1;
                    n_ix      = '0;
                    n_srch_y  = 1'b1;
                    n_sel     = 1'b1;
                    n_hi      = IW'(r_y_cnt - YCW'(1));
                    n_status  = (r_qx < r_x0) ? ST_EXTRAP : ST_INTERP;
                end else if (r_qx >= r_xl && y_in) begin
                    n_outer_x = 1'b1;
                    n_ix      = IW'(r_x_cnt - XCW'(2));
                    n_srch_y  = 1'b1;
                    n_sel     = 1'b1;
                    n_hi      = IW'(r_y_cnt - YCW'(1));
                    n_status  = (r_qx > r_xl) ? ST_EXTRAP : ST_INTERP;
                end else if (r_qy <= r_y0 && x_in) begin
                    n_outer_x = 1'b0;
                    n_iy      = '0;
                    n_srch_y  = 1'b0;
                    n_status  = (r_qy < r_y0) ? ST_EXTRAP : ST_INTERP;
                end else if (r_qy >= r_bp_q && x_in) begin
                    n_outer_x = 1'b0;
                    n_iy      = IW'(r_y_cnt - YCW'(2));
                    n_srch_y  = 1'b0;
                    n_status  = (r_qy > r_bp_q) ? ST_EXTRAP : ST_INTERP;
                end else if (r_qx < r_x0 || r_qx > r_xl || r_qy < r_y0 || r_qy > r_bp_q) begin
                    n_res    = '0;
                    n_status = ST_OOR;
                    n_state  = S_MFIN;
                    n_step   = 2'd3;
                end else begin
                    n_outer_x = 1'b0;
                    n_srch_y  = 1'b1;
                end
            end
            S_SRD: begin
                if (s_span > (IW+1)'(1)) begin
                    bp_raddr = BAW'((r_sel ? 32'(MX) : 32'd0) + 32'(s_mid));
                    n_mid    = s_mid;
                    n_state  = S_SCMP;
                end else if (!r_sel) begin
                    n_ix = r_lo;
                    if (r_srch_y) begin
                        n_sel = 1'b1;
                        n_lo  = '0;
                        n_hi  = IW'(r_y_cnt - YCW'(1));
                    end else begin
                        n_state = S_FRD0;
                    end
                end else begin
                    n_iy    = r_lo;
                    n_sel   = 1'b0;
                    n_state = S_FRD0;
                end
            end
            S_SCMP: begin
                if (q_sel > r_bp_q) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SRD;
            end
            S_FRD0: begin
                bp_raddr = BAW'((r_sel ? 32'(MX) : 32'd0) + 32'(idx_sel));
                n_state  = S_FRD1;
            end
            S_FRD1: begin
                bp_raddr = BAW'((r_sel ? 32'(MX) : 32'd0) + 32'(idx_sel) + 32'd1);
                n_base   = r_bp_q;
                n_state  = S_FDEN;
            end
            S_FDEN: begin
                if (fr_den[32] || fr_den == 33'sd0) begin
                    if (!r_sel) begin
                        n_fx_mag = '0;
                        n_fx_neg = 1'b0;
                        n_sel    = 1'b1;
                        n_state  = S_FRD0;
                    end else begin
                        n_fy_mag = '0;
                        n_fy_neg = 1'b0;
                        n_gk     = '0;
                        n_state  = S_GRD;
                    end
                end else begin
                    n_den   = fr_den[31:0];
                    n_div_q = {num_mag, 16'd0};
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_dneg  = fr_num[32];
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem   = div_r;
                n_div_q = {r_div_q[QUO_W-2:0], div_ge};
                n_dcnt  = r_dcnt + 6'd1;
                if (r_dcnt == 6'(QUO_W - 1)) begin
                    if (!r_sel) begin
                        n_fx_mag = {r_div_q[QUO_W-2:0], div_ge};
                        n_fx_neg = r_dneg;
                        n_sel    = 1'b1;
                        n_state  = S_FRD0;
                    end else begin
                        n_fy_mag = {r_div_q[QUO_W-2:0], div_ge};
                        n_fy_neg = r_dneg;
                        n_gk     = '0;
                        n_state  = S_GRD;
                    end
                end
            end
            S_GRD: begin
                n_gk = r_gk + 3'd1;
                if (r_gk == 3'd4) begin
                    n_step  = 2'd0;
                    n_state = S_MI;
                end
            end
            S_MI: begin
                n_ua    = lp_ua;
                n_mneg  = lp_diff[DIF_W-1] ^ lp_fneg;
                n_acc   = '0;
                n_sat   = 1'b0;
                n_mk    = 2'd3;
                n_state = S_MACC;
            end
            S_MACC: begin
                n_acc = macc[ACC_W-1:0];
                n_sat = r_sat || (macc[73:ACC_W] != '0);
                n_mk  = r_mk - 2'd1;
                if (r_mk == 2'd0) begin
                    n_state = S_MFIN;
                end
            end
            S_MFIN: begin
                case (r_step)
                    2'd0: begin
                        n_l0    = lres;
                        n_step  = 2'd1;
                        n_state = S_MI;
                    end
                    2'd1: begin
                        n_l1    = lres;
                        n_step  = 2'd2;
                        n_state = S_MI;
                    end
                    2'd2: begin
                        n_res  = res32;
                        n_step = 2'd3;
                    end
                    default: begin
                        if (!r_out_valid || !i_out_stall) begin
                            n_out_valid  = 1'b1;
                            n_out_value  = r_res;
                            n_out_status = r_status;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_x_cnt     <= XCW'(2);
            r_y_cnt     <= YCW'(2);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_x_cnt     <= n_x_cnt;
            r_y_cnt     <= n_y_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_qx <= n_qx;  r_qy <= n_qy;
        r_x0 <= n_x0;  r_xl <= n_xl;  r_y0 <= n_y0;
        r_outer_x <= n_outer_x;  r_srch_y <= n_srch_y;  r_status <= n_status;
        r_sel <= n_sel;  r_lo <= n_lo;  r_hi <= n_hi;  r_mid <= n_mid;
        r_ix <= n_ix;  r_iy <= n_iy;  r_base <= n_base;
        r_div_q <= n_div_q;  r_rem <= n_rem;  r_den <= n_den;
        r_dcnt <= n_dcnt;  r_dneg <= n_dneg;
        r_fx_mag <= n_fx_mag;  r_fx_neg <= n_fx_neg;
        r_fy_mag <= n_fy_mag;  r_fy_neg <= n_fy_neg;
        r_gk <= n_gk;  r_step <= n_step;
        r_ua <= n_ua;  r_mneg <= n_mneg;  r_acc <= n_acc;  r_sat <= n_sat;  r_mk <= n_mk;
        r_l0 <= n_l0;  r_l1 <= n_l1;  r_res <= n_res;
        if (corner_we) begin
            r_corner[corner_wi] <= r_g_q;
        end
    end

    `BTI_ASSERT_ALWAYS(a_cnt_range, (r_x_cnt >= XCW'(2)) && (r_x_cnt <= XCW'(MX)) && (r_y_cnt >= YCW'(2)) && (r_y_cnt <= YCW'(MY)), "point count out of range")
    `BTI_ASSERT_IMPL(a_search_order, (r_state == S_SRD), (r_lo < r_hi), "search bounds crossed")
    `BTI_ASSERT_IMPL(a_oor_zero, (o_out_valid && o_status == ST_OOR), (o_interp_value == 32'sd0), "out of range item has nonzero value")
    `BTI_ASSERT_NEXT(a_query_start, (i_in_valid && !o_in_stall && i_command == CMD_QUERY), (r_state == S_RX0), "query item did not start")

endmodule
`default_nettype wire

// ===== test/bilinear_table_interpolator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear table interpolator testbench
// Loads breakpoint tables and value grids for several point counts, sends
// directed and random queries with random gaps on both sides, and checks
// every result against a Q16.16 bilinear interpolation predictor.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator_tb;
    import bti_pkg::*;

    localparam int  NMAX = 64;
    localparam longint BLEND_LIM = 64'sd1 << 40;
    localparam int  RUN_LIMIT = 1500000;
    localparam int  DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } interp_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_command = CMD_LOAD_X;
    logic [5:0]         i_x_slot = '0;
    logic [5:0]         i_y_slot = '0;
    logic signed [31:0] i_load_word = '0;
    logic signed [31:0] i_query_x = '0;
    logic signed [31:0] i_query_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_interp_value;
    logic [1:0]         o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = REG_X_COUNT;
    logic [6:0]         i_cfg_data = 7'd2;

    bilinear_table_interpolator dut (.*);

    always #5 i_clk = ~i_clk;

    int x_points;
    int y_points;
    longint x_table [NMAX];
    longint y_table [NMAX];
    longint value_table [NMAX*NMAX];

    interp_result_t pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  queries_sent = 0;
    int  loads_sent = 0;
    int  extrap_seen = 0;
    int  oor_seen = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    int  hold_long = 0;
    int  out_wait = 0;

    function automatic longint fraction_q16(longint num, longint den);
        if (den <= 0) return 0;
        return (num * 65536) / den;
    endfunction

    function automatic longint scale_q16(longint a, longint f);
        bit neg;
        longint unsigned ua, uf, mag;
        neg = (a < 0) != (f < 0);
        ua = (a < 0) ? longint'(0) - a : a;
        uf = (f < 0) ? longint'(0) - f : f;
        if (ua != 0 && uf > (64'd1 << 62) / ua) begin
            mag = BLEND_LIM;
        end else begin
            mag = (ua * uf) >> 16;
            if (mag > BLEND_LIM) mag = BLEND_LIM;
        end
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return clamp(a + scale_q16(b - a, f), -BLEND_LIM, BLEND_LIM);
    endfunction

    function automatic longint breakpoint(bit is_y, int k);
        return is_y ? y_table[k] : x_table[k];
    endfunction

    function automatic int find_cell(bit is_y, int n, longint v);
        int lo, hi, mid;
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (v > breakpoint(is_y, mid)) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    function automatic longint grid_at(int col, int row);
        return value_table[col*NMAX + row];
    endfunction

    function automatic longint value_along_x(int row, longint x);
        int i;
        longint f;
        i = find_cell(1'b0, x_points, x);
        f = fraction_q16(x - x_table[i], x_table[i+1] - x_table[i]);
        return blend(grid_at(i, row), grid_at(i + 1, row), f);
    endfunction

    function automatic longint value_along_y(int col, longint y);
        int j;
        longint f;
        j = find_cell(1'b1, y_points, y);
        f = fraction_q16(y - y_table[j], y_table[j+1] - y_table[j]);
        return blend(grid_at(col, j), grid_at(col, j + 1), f);
    endfunction

    function automatic interp_result_t interpolate(longint x, longint y);
        interp_result_t r;
        longint x0, xl, y0, yl, f, t, u, v, r0, r1;
        int i, j;
        int nx, ny;
        nx = x_points;
        ny = y_points;
        x0 = x_table[0];
        xl = x_table[nx-1];
        y0 = y_table[0];
        yl = y_table[ny-1];
        r.status = ST_INTERP;
        if (x <= x0 && y > y0 && y < yl) begin
            f = fraction_q16(x - x0, x_table[1] - x0);
            v = blend(value_along_y(0, y), value_along_y(1, y), f);
            if (x < x0) r.status = ST_EXTRAP;
        end else if (x >= xl && y > y0 && y < yl) begin
            f = fraction_q16(x - x_table[nx-2], xl - x_table[nx-2]);
            v = blend(value_along_y(nx - 2, y), value_along_y(nx - 1, y), f);
            if (x > xl) r.status = ST_EXTRAP;
        end else if (y <= y0 && x > x0 && x < xl) begin
            f = fraction_q16(y - y0, y_table[1] - y0);
            v = blend(value_along_x(0, x), value_along_x(1, x), f);
            if (y < y0) r.status = ST_EXTRAP;
        end else if (y >= yl && x > x0 && x < xl) begin
            f = fraction_q16(y - y_table[ny-2], yl - y_table[ny-2]);
            v = blend(value_along_x(ny - 2, x), value_along_x(ny - 1, x), f);
            if (y > yl) r.status = ST_EXTRAP;
        end else if (x < x0 || x > xl || y < y0 || y > yl) begin
            v = 0;
            r.status = ST_OOR;
        end else begin
            i = find_cell(1'b0, nx, x);
            j = find_cell(1'b1, ny, y);
            t = fraction_q16(x - x_table[i], x_table[i+1] - x_table[i]);
            u = fraction_q16(y - y_table[j], y_table[j+1] - y_table[j]);
            r0 = blend(grid_at(i, j), grid_at(i + 1, j), t);
            r1 = blend(grid_at(i, j + 1), grid_at(i + 1, j + 1), t);
            v = blend(r0, r1, u);
        end
        v = clamp(v, -64'sd2147483648, 64'sd2147483647);
        r.value = v[31:0];
        return r;
    endfunction

    // Sends one item; the caller stands at a rising edge.
    task automatic send_item(logic [1:0] cmd, logic [5:0] xs, logic [5:0] ys,
                             logic [31:0] word, logic [31:0] qx, logic [31:0] qy);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_x_slot    <= xs;
        i_y_slot    <= ys;
        i_load_word <= word;
        i_query_x   <= qx;
        i_query_y   <= qy;
        do @(posedge i_clk); while (o_in_stall);
        case (cmd)
            CMD_LOAD_X: x_table[xs] = $signed(word);
            CMD_LOAD_Y: y_table[ys] = $signed(word);
            CMD_LOAD_G: value_table[xs*NMAX + ys] = $signed(word);
            default: begin
                pending_results.push_back(interpolate($signed(qx), $signed(qy)));
                queries_sent++;
            end
        endcase
        if (cmd != CMD_QUERY) loads_sent++;
    endtask

    task automatic query(logic [31:0] qx, logic [31:0] qy);
        send_item(CMD_QUERY, $urandom, $urandom, $urandom, qx, qy);
    endtask

    task automatic load(logic [1:0] cmd, int xs, int ys, logic [31:0] word);
        send_item(cmd, xs, ys, word, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic idx, logic [6:0] raw);
        int c;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        c = (raw < 2) ? 2 : ((raw > NMAX) ? NMAX : raw);
        if (idx == REG_X_COUNT) x_points = c;
        else y_points = c;
    endtask

    function automatic logic [31:0] grid_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(8, 20);
        endcase
    endfunction

    function automatic logic [31:0] pick_coord(bit is_y, int n);
        longint lo, hi, v, tmp;
        lo = breakpoint(is_y, 0);
        hi = breakpoint(is_y, n - 1);
        if (hi < lo) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = lo + longint'($urandom) % (hi - lo + 1);
            4: v = breakpoint(is_y, $urandom_range(0, n - 1));
            5: v = lo - $urandom_range(1, 32'h40000);
            6: v = hi + $urandom_range(1, 32'h40000);
            7: v = $signed($urandom);
            8: v = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
            default: v = $urandom_range(0, 1) ? hi : lo;
        endcase
        v = clamp(v, -64'sd2147483648, 64'sd2147483647);
        return v[31:0];
    endfunction

    task automatic load_breakpoints(logic [1:0] cmd, int n, bit ordered);
        longint span, lo, v;
        if ($urandom_range(0, 1)) span = $urandom_range(n - 1, 32'hFFFF_FFFE);
        else span = $urandom_range(n - 1, n * 4096);
        lo = -64'sd2147483648 + longint'($urandom) % (64'sd4294967296 - span);
        for (int k = 0; k < n; k++) begin
            v = ordered ? lo + span * k / (n - 1) : longint'($signed($urandom)) >>> 4;
            load(cmd, k, k, v[31:0]);
        end
    endtask

    task automatic test_directed_corners();
        write_count(REG_X_COUNT, 7'd0);
        write_count(REG_Y_COUNT, 7'd1);
        load(CMD_LOAD_X, 0, 0, 32'h0000_0000);
        load(CMD_LOAD_X, 1, 0, 32'h0001_0000);
        load(CMD_LOAD_Y, 0, 0, 32'hFFFE_0000);
        load(CMD_LOAD_Y, 0, 1, 32'h0002_0000);
        load(CMD_LOAD_G, 0, 0, 32'h7FFF_FFFF);
        load(CMD_LOAD_G, 1, 0, 32'h8000_0000);
        load(CMD_LOAD_G, 0, 1, 32'h0000_0000);
        load(CMD_LOAD_G, 1, 1, 32'h1234_5678);
        query(32'h0000_8000, 32'h0000_0000);
        query(32'h0000_0000, 32'hFFFE_0000);
        query(32'h0001_0000, 32'h0002_0000);
        query(32'h0000_0000, 32'h0000_0000);
        query(32'hFFFF_0000, 32'h0000_0000);
        query(32'h7FFF_FFFF, 32'h0000_1000);
        query(32'h8000_0000, 32'hFFFF_F000);
        query(32'h0000_8000, 32'h8000_0000);
        query(32'h0000_8000, 32'h7FFF_FFFF);
        query(32'h0002_0000, 32'h0003_0000);
        query(32'h0002_0000, 32'h0002_0000);
        query(32'h8000_0000, 32'h8000_0000);
        query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query(32'h0000_4000, 32'h0001_0000);
    endtask

    task automatic run_queries(int count);
        for (int q = 0; q < count; q++) begin
            no_idle = ((q / 40) % 3) == 0;
            if ($urandom_range(0, 99) < 8) begin
                load(CMD_LOAD_G, $urandom, $urandom, grid_word());
            end else if ($urandom_range(0, 99) < 3 && x_points < NMAX) begin
                load(CMD_LOAD_X, $urandom_range(x_points, NMAX - 1), 0, $urandom);
            end
            query(pick_coord(1'b0, x_points), pick_coord(1'b1, y_points));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_tables(logic [6:0] raw_x, logic [6:0] raw_y, bit ordered,
                               int count);
        write_count(REG_X_COUNT, raw_x);
        write_count(REG_Y_COUNT, raw_y);
        load_breakpoints(CMD_LOAD_X, x_points, ordered);
        load_breakpoints(CMD_LOAD_Y, y_points, ordered);
        for (int c = 0; c < x_points; c++) begin
            for (int r = 0; r < y_points; r++) load(CMD_LOAD_G, c, r, grid_word());
        end
        run_queries(count);
    endtask

    task automatic test_output_backpressure();
        hold_long = 3000;
        run_queries(150);
    endtask

    always @(posedge i_clk) begin
        interp_result_t exp_r;
        cycles++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_status == ST_EXTRAP) extrap_seen++;
            if (o_status == ST_OOR) oor_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: value %h status %0d",
                             o_interp_value, o_status);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_interp_value !== exp_r.value || o_status !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at result %0d: expected %h/%0d, got %h/%0d",
                                 results_seen, exp_r.value, exp_r.status,
                                 o_interp_value, o_status);
                end
            end
            out_wait = no_idle ? 0 : $urandom_range(0, 12);
        end
        if (hold_long > 0) begin
            hold_long--;
            i_out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        x_points = 2;
        y_points = 2;
        foreach (x_table[k]) x_table[k] = 0;
        foreach (y_table[k]) y_table[k] = 0;
        foreach (value_table[k]) value_table[k] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_tables(7'd4, 7'd3, 1'b1, 150);
        test_tables(7'd127, 7'd100, 1'b1, 250);
        test_tables(7'd2, 7'd64, 1'b1, 80);
        test_tables(7'd64, 7'd2, 1'b1, 80);
        test_tables(7'd5, 7'd5, 1'b0, 120);
        test_output_backpressure();
        wait_idle();
        if (pending_results.size() != 0) mismatches += pending_results.size();
        $display("Sent %0d queries and %0d loads over point counts from 2 to 64.",
                 queries_sent, loads_sent);
        $display("Checked %0d results: %0d extrapolated, %0d out of range.",
                 results_seen, extrap_seen, oor_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
